// File: hw/rtl/servo_move_settle_sequencer_unit_macros.svh
// Assertion macros for the servo move and settle sequencer.
`ifndef SERVO_MOVE_SETTLE_SEQUENCER_UNIT_MACROS_SVH
`define SERVO_MOVE_SETTLE_SEQUENCER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SVMSS_ASSERT_NOW(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("svmss assertion failed: same-cycle check");
// Next-cycle implication.
`define SVMSS_ASSERT_NEXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("svmss assertion failed: next-cycle check");
`else
`define SVMSS_ASSERT_NOW(name, pre, post)
`define SVMSS_ASSERT_NEXT(name, pre, post)
`endif

`endif

// File: hw/rtl/svmss_pkg.sv
// Shared constants and types of the servo move and settle sequencer.
package svmss_pkg;

   localparam int ANGLE_W   = 8;
   localparam int PULSE_W   = 16;
   localparam int PDIV_W    = 20;
   localparam int CFG_W     = 20;
   localparam int CFG_IDX_W = 3;
   localparam int OP_W      = 3;
   localparam int PHASE_W   = 2;
   localparam int TICK_W    = 16;
   localparam int SETTLE_W  = 9;

   // register indexes
   localparam logic [CFG_IDX_W-1:0] CFG_TIMER_PERIOD = 3'd0;
   localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE    = 3'd1;
   localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE    = 3'd2;
   localparam logic [CFG_IDX_W-1:0] CFG_PULSE_DIV    = 3'd3;
   localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANGLE    = 3'd4;

   localparam logic [PULSE_W-1:0] RST_TIMER_PERIOD = 16'd19999;
   localparam logic [PULSE_W-1:0] RST_MIN_PULSE    = 16'd500;
   localparam logic [PULSE_W-1:0] RST_MAX_PULSE    = 16'd2500;
   localparam logic [PDIV_W-1:0]  RST_PULSE_DIV    = 20'd20000;
   localparam logic [ANGLE_W-1:0] RST_MAX_ANGLE    = 8'd180;
   localparam logic [ANGLE_W-1:0] RST_TARGET       = 8'd90;

   // opcodes
   localparam logic [OP_W-1:0] OP_SET_TARGET  = 3'd0;
   localparam logic [OP_W-1:0] OP_SET_CURRENT = 3'd1;
   localparam logic [OP_W-1:0] OP_STEP        = 3'd2;
   localparam logic [OP_W-1:0] OP_TICK        = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR_BLOCK = 3'd4;

   // phases
   localparam logic [PHASE_W-1:0] PH_IDLE    = 2'd0;
   localparam logic [PHASE_W-1:0] PH_SETTLE  = 2'd1;
   localparam logic [PHASE_W-1:0] PH_MEASURE = 2'd2;
   localparam logic [PHASE_W-1:0] PH_ERROR   = 2'd3;

   // shared divider: radix 4 restoring, two quotient bits a cycle
   localparam int DVD_W     = 42;
   localparam int DSR_W     = 20;
   localparam int DIV_STEPS = DVD_W / 2;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

   // divider operand selects
   localparam logic [1:0] DSEL_HI    = 2'd0;
   localparam logic [1:0] DSEL_LO    = 2'd1;
   localparam logic [1:0] DSEL_SCALE = 2'd2;

   localparam int RSP_TDATA_W = 40;

   typedef struct packed {
      logic       latch;
      logic       exec;
      logic       div_start;
      logic [1:0] start_sel;
      logic       div_cap;
      logic [1:0] cap_sel;
      logic       cmp_write;
      logic       rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic move;
      logic div_busy;
      logic div_done;
   } dp_status_type;

   // last member sits in the lowest bits
   typedef struct packed {
      logic               ready_res;
      logic               angle_error;
      logic               compare_write;
      logic [PULSE_W-1:0] compare_value;
      logic [ANGLE_W-1:0] goal_angle;
      logic [ANGLE_W-1:0] present_angle;
      logic               block_flag;
      logic [PHASE_W-1:0] phase;
   } rsp_payload_type;

endpackage

// File: hw/rtl/svmss_div.sv
// Iterative unsigned divider, two quotient bits per cycle.
module svmss_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [svmss_pkg::DVD_W-1:0]   dividend,
   input  logic [svmss_pkg::DSR_W-1:0]   divisor,
   output logic                          busy,
   output logic                          done,
   output logic [svmss_pkg::DVD_W-1:0]   quotient
);
   import svmss_pkg::*;

   logic [DVD_W-1:0]     dvd_ff, dvd_in;
   logic [DVD_W-1:0]     quo_ff, quo_in;
   logic [DSR_W-1:0]     dsr_ff, dsr_in;
   logic [DSR_W-1:0]     rem_ff, rem_in;
   logic [DSR_W-1:0]     rem_mid, rem_end;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DSR_W:0]       try_a, try_b;
   logic                 ge_a, ge_b;

   always_comb begin
      try_a   = {rem_ff, dvd_ff[DVD_W-1]};
      ge_a    = try_a >= {1'b0, dsr_ff};
      rem_mid = ge_a ? DSR_W'(try_a - {1'b0, dsr_ff}) : try_a[DSR_W-1:0];
      try_b   = {rem_mid, dvd_ff[DVD_W-2]};
      ge_b    = try_b >= {1'b0, dsr_ff};
      rem_end = ge_b ? DSR_W'(try_b - {1'b0, dsr_ff}) : try_b[DSR_W-1:0];

      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         dsr_in  = divisor;
         quo_in  = '0;
         rem_in  = '0;
         cnt_in  = DIV_CNT_W'(DIV_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DVD_W-3:0], 2'b00};
         quo_in = {quo_ff[DVD_W-3:0], ge_a, ge_b};
         rem_in = rem_end;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: hw/rtl/svmss_dp.sv
// Datapath: config registers, servo state, pulse arithmetic and result register.
module svmss_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [svmss_pkg::CFG_IDX_W-1:0]  csr_index,
   input  logic [svmss_pkg::CFG_W-1:0]      csr_wdata,
   input  logic [svmss_pkg::OP_W-1:0]       req_opcode,
   input  logic [svmss_pkg::ANGLE_W-1:0]    req_angle,
   input  svmss_pkg::dp_cmd_type            cmd,
   output svmss_pkg::dp_status_type         status,
   output svmss_pkg::rsp_payload_type       payload
);
   import svmss_pkg::*;

   localparam int FRAME_W = PULSE_W + 1;
   localparam int PROD_W  = FRAME_W + PULSE_W;     // pulse in timer counts, before divide
   localparam int SCL_W   = PROD_W + ANGLE_W;
   localparam int SUM_W   = SCL_W + 1;
   localparam int X5_W    = ANGLE_W + 3;
   localparam int SPROD_W = 20;
   localparam logic [SPROD_W-1:0]  SETTLE_RECIP = 20'd683;   // 2^11/3, exact for 5*d <= 1275
   localparam int                  SETTLE_SHIFT = 11;
   localparam logic [SETTLE_W-1:0] SETTLE_BIAS  = 9'd10;

   // configuration
   logic [PULSE_W-1:0] timer_period_ff, min_pulse_ff, max_pulse_ff;
   logic [PDIV_W-1:0]  pulse_div_ff;
   logic [ANGLE_W-1:0] max_angle_ff;

   // latched item
   logic [OP_W-1:0]    op_ff;
   logic [ANGLE_W-1:0] ang_ff;

   // servo state
   logic [PHASE_W-1:0]  phase_ff, phase_in;
   logic [ANGLE_W-1:0]  cur_ff, cur_in;
   logic [ANGLE_W-1:0]  tgt_ff, tgt_in;
   logic                blocked_ff, blocked_in;
   logic [TICK_W-1:0]   tick_ff, tick_in;
   logic [SETTLE_W-1:0] settle_ff, settle_in;
   logic [PULSE_W-1:0]  compare_ff, compare_in;
   logic                wrote_ff, wrote_in;
   logic                err_ff, err_in;

   // pulse arithmetic
   logic [PROD_W-1:0]   p1_ff, p0_ff;
   logic [SCL_W-1:0]    dq_ff;
   rsp_payload_type     payload_ff;

   logic                move;
   logic                ang_ok;
   logic [ANGLE_W-1:0]  ang_diff;
   logic [X5_W-1:0]     x5;
   logic [SPROD_W-1:0]  settle_prod;
   logic [SETTLE_W-1:0] settle_new;
   logic [FRAME_W-1:0]  frame;
   logic [PROD_W-1:0]   prod_hi, prod_lo;
   logic [DSR_W-1:0]    pdiv_eff, full_eff;
   logic                p_ge;
   logic [PROD_W-1:0]   p_mag;
   logic [SCL_W-1:0]    scale_prod;
   logic [DVD_W-1:0]    div_dividend;
   logic [DSR_W-1:0]    div_divisor;
   logic [DVD_W-1:0]    div_quotient;
   logic                div_busy, div_done;
   logic [SUM_W-1:0]    s_val;
   logic                s_neg;
   logic [PULSE_W-1:0]  cmp_new;

   svmss_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         timer_period_ff <= RST_TIMER_PERIOD;
         min_pulse_ff    <= RST_MIN_PULSE;
         max_pulse_ff    <= RST_MAX_PULSE;
         pulse_div_ff    <= RST_PULSE_DIV;
         max_angle_ff    <= RST_MAX_ANGLE;
      end else if (csr_we) begin
         unique case (csr_index)
            CFG_TIMER_PERIOD: timer_period_ff <= csr_wdata[PULSE_W-1:0];
            CFG_MIN_PULSE:    min_pulse_ff    <= csr_wdata[PULSE_W-1:0];
            CFG_MAX_PULSE:    max_pulse_ff    <= csr_wdata[PULSE_W-1:0];
            CFG_PULSE_DIV:    pulse_div_ff    <= csr_wdata[PDIV_W-1:0];
            CFG_MAX_ANGLE:    max_angle_ff    <= csr_wdata[ANGLE_W-1:0];
            default: ;
         endcase
      end
   end

   // settle time and move detection
   always_comb begin
      move     = (op_ff == OP_STEP) && !blocked_ff && (phase_ff == PH_IDLE) &&
                 (cur_ff != tgt_ff);
      ang_ok   = ang_ff <= max_angle_ff;
      ang_diff = (cur_ff > tgt_ff) ? (cur_ff - tgt_ff) : (tgt_ff - cur_ff);
      // 100*d/60 = 5*d/3
      x5          = X5_W'({ang_diff, 2'b00}) + X5_W'(ang_diff);
      settle_prod = SPROD_W'(x5) * SETTLE_RECIP;
      settle_new  = settle_prod[SETTLE_SHIFT +: SETTLE_W] + SETTLE_BIAS;
   end

   // divider operands
   always_comb begin
      frame      = FRAME_W'(timer_period_ff) + 1'b1;
      prod_hi    = PROD_W'(frame) * PROD_W'(max_pulse_ff);
      prod_lo    = PROD_W'(frame) * PROD_W'(min_pulse_ff);
      pdiv_eff   = (pulse_div_ff == '0) ? DSR_W'(1) : DSR_W'(pulse_div_ff);
      full_eff   = (max_angle_ff == '0) ? DSR_W'(1) : DSR_W'(max_angle_ff);
      p_ge       = p1_ff >= p0_ff;
      p_mag      = p_ge ? (p1_ff - p0_ff) : (p0_ff - p1_ff);
      scale_prod = SCL_W'(p_mag) * SCL_W'(tgt_ff);
      case (cmd.start_sel)
         DSEL_HI:    div_dividend = DVD_W'(prod_hi);
         DSEL_LO:    div_dividend = DVD_W'(prod_lo);
         DSEL_SCALE: div_dividend = DVD_W'(scale_prod);
         default:    div_dividend = '0;
      endcase
      div_divisor = (cmd.start_sel == DSEL_SCALE) ? full_eff : pdiv_eff;
   end

   // p0 +/- scaled span, minus one, clamped to 16 bits
   always_comb begin
      s_neg = !p_ge && (SCL_W'(p0_ff) < dq_ff);
      if (p_ge) begin
         s_val = SUM_W'(p0_ff) + SUM_W'(dq_ff);
      end else begin
         s_val = SUM_W'(p0_ff) - SUM_W'(dq_ff);
      end
      if (s_neg) begin
         cmp_new = '1;
      end else if (s_val == '0) begin
         cmp_new = '0;
      end else if (s_val > SUM_W'(17'h10000)) begin
         cmp_new = '1;
      end else begin
         cmp_new = PULSE_W'(s_val - 1'b1);
      end
   end

   // state update
   always_comb begin
      phase_in   = phase_ff;
      cur_in     = cur_ff;
      tgt_in     = tgt_ff;
      blocked_in = blocked_ff;
      tick_in    = tick_ff;
      settle_in  = settle_ff;
      compare_in = compare_ff;
      wrote_in   = wrote_ff;
      err_in     = err_ff;
      if (cmd.exec) begin
         wrote_in = 1'b0;
         err_in   = 1'b0;
         case (op_ff)
            OP_SET_TARGET: begin
               if (ang_ok) tgt_in = ang_ff;
               else err_in = 1'b1;
            end
            OP_SET_CURRENT: begin
               if (ang_ok) cur_in = ang_ff;
               else err_in = 1'b1;
            end
            OP_STEP: begin
               if (!blocked_ff) begin
                  case (phase_ff)
                     PH_IDLE: begin
                        if (move) begin
                           phase_in  = PH_SETTLE;
                           cur_in    = tgt_ff;
                           settle_in = settle_new;
                           tick_in   = '0;
                           wrote_in  = 1'b1;
                        end
                     end
                     PH_SETTLE: begin
                        if (tick_ff >= TICK_W'(settle_ff)) begin
                           settle_in  = '0;
                           phase_in   = PH_MEASURE;
                           blocked_in = 1'b1;
                        end
                     end
                     PH_MEASURE: phase_in = PH_IDLE;
                     PH_ERROR:   ;
                     default:    ;
                  endcase
               end
            end
            OP_TICK: begin
               if (tick_ff != '1) tick_in = tick_ff + 1'b1;
            end
            OP_CLEAR_BLOCK: blocked_in = 1'b0;
            default: ;
         endcase
      end
      if (cmd.cmp_write) compare_in = cmp_new;
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff  <= req_opcode;
         ang_ff <= req_angle;
      end
      if (cmd.div_cap) begin
         case (cmd.cap_sel)
            DSEL_HI:    p1_ff <= div_quotient[PROD_W-1:0];
            DSEL_LO:    p0_ff <= div_quotient[PROD_W-1:0];
            DSEL_SCALE: dq_ff <= div_quotient[SCL_W-1:0];
            default: ;
         endcase
      end
      if (cmd.rsp_load) begin
         payload_ff.ready_res     <= (phase_ff == PH_IDLE) && (cur_ff == tgt_ff);
         payload_ff.angle_error   <= err_ff;
         payload_ff.compare_write <= wrote_ff;
         payload_ff.compare_value <= compare_ff;
         payload_ff.goal_angle    <= tgt_ff;
         payload_ff.present_angle <= cur_ff;
         payload_ff.block_flag    <= blocked_ff;
         payload_ff.phase         <= phase_ff;
      end
      wrote_ff <= wrote_in;
      err_ff   <= err_in;
      if (reset) begin
         phase_ff   <= PH_IDLE;
         cur_ff     <= '0;
         tgt_ff     <= RST_TARGET;
         blocked_ff <= 1'b0;
         tick_ff    <= '0;
         settle_ff  <= '0;
         compare_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         cur_ff     <= cur_in;
         tgt_ff     <= tgt_in;
         blocked_ff <= blocked_in;
         tick_ff    <= tick_in;
         settle_ff  <= settle_in;
         compare_ff <= compare_in;
      end
   end

   assign status.move     = move;
   assign status.div_busy = div_busy;
   assign status.div_done = div_done;
   assign payload         = payload_ff;

endmodule

// File: hw/rtl/svmss_ctrl.sv
// Controller: item handshake, divide sequencing and result valid.
module svmss_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  svmss_pkg::dp_status_type  status,
   output svmss_pkg::dp_cmd_type     cmd
);
   import svmss_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_EXEC  = 3'd1;
   localparam logic [2:0] ST_DIVH  = 3'd2;
   localparam logic [2:0] ST_DIVL  = 3'd3;
   localparam logic [2:0] ST_SPREP = 3'd4;
   localparam logic [2:0] ST_DIVS  = 3'd5;
   localparam logic [2:0] ST_FINAL = 3'd6;
   localparam logic [2:0] ST_DONE  = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (status.move) begin
               cmd.div_start = 1'b1;
               cmd.start_sel = DSEL_HI;
               state_in      = ST_DIVH;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DIVH: begin
            if (status.div_done) begin
               cmd.div_cap   = 1'b1;
               cmd.cap_sel   = DSEL_HI;
               cmd.div_start = 1'b1;
               cmd.start_sel = DSEL_LO;
               state_in      = ST_DIVL;
            end
         end
         ST_DIVL: begin
            if (status.div_done) begin
               cmd.div_cap = 1'b1;
               cmd.cap_sel = DSEL_LO;
               state_in    = ST_SPREP;
            end
         end
         ST_SPREP: begin
            cmd.div_start = 1'b1;
            cmd.start_sel = DSEL_SCALE;
            state_in      = ST_DIVS;
         end
         ST_DIVS: begin
            if (status.div_done) begin
               cmd.div_cap = 1'b1;
               cmd.cap_sel = DSEL_SCALE;
               state_in    = ST_FINAL;
            end
         end
         ST_FINAL: begin
            cmd.cmp_write = 1'b1;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (cmd.rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// File: hw/rtl/servo_move_settle_sequencer_unit.sv
// Top level of the servo move and settle sequencer.
// A command beat is latched, executed and loaded into the result register; a move
// step also runs three passes through the shared 2-bit-per-cycle divider.
// Only one item is in flight: a new beat is taken after the previous result is loaded.
// Reset: synchronous, active high; resets controller and servo state and restores default config.
`include "servo_move_settle_sequencer_unit_macros.svh"
module servo_move_settle_sequencer_unit (
   input  logic                              clock,
   input  logic                              reset,
   // configuration write port
   input  logic                              csr_we,
   input  logic [svmss_pkg::CFG_IDX_W-1:0]   csr_index,
   input  logic [svmss_pkg::CFG_W-1:0]       csr_wdata,
   // command beats
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [svmss_pkg::ANGLE_W-1:0]     req_tdata,   // [7:0] angle
   input  logic [svmss_pkg::OP_W-1:0]        req_tuser,   // [2:0] opcode
   // result beats
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [1:0] phase, [2] block_flag, [10:3] present_angle, [18:11] goal_angle,
   // [34:19] compare_value, [35] compare_write, [36] angle_error,
   // [37] ready_res, [39:38] zero
   output logic [svmss_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import svmss_pkg::*;

   localparam int RSP_PAD_W = RSP_TDATA_W - $bits(rsp_payload_type);

   // Controller walks each item through exec; a step that moves the servo
   // then runs the pulse math (p1 divide, p0 divide, angle scale divide,
   // combine) before the result beat is loaded. The result register lets the
   // next command beat in while the previous result waits downstream.
   dp_cmd_type      dp_cmd;
   dp_status_type   dp_status;
   rsp_payload_type rsp_payload;

   svmss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (dp_status),
      .cmd        (dp_cmd)
   );

   svmss_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_opcode (req_tuser),
      .req_angle  (req_tdata),
      .cmd        (dp_cmd),
      .status     (dp_status),
      .payload    (rsp_payload)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp_payload};

   // one item in flight: no second beat right after an accepted one
   `SVMSS_ASSERT_NEXT(a_one_item_in_flight, req_tvalid && req_tready, !req_tready)
   // a result is only loaded into a free or draining output register
   `SVMSS_ASSERT_NOW(a_rsp_slot_free, dp_cmd.rsp_load, !rsp_tvalid || rsp_tready)
   // divider is never restarted in the middle of a divide
   `SVMSS_ASSERT_NOW(a_div_idle_on_start, dp_cmd.div_start, !dp_status.div_busy)

endmodule
